FILE: hw/rtl/dam_pkg.sv
package dam_pkg;

    localparam int MemWords  = 100;
    localparam int AddrW     = 7;
    localparam int WordW     = 32;
    localparam int QuoW      = 25;
    localparam int InDataW   = 40;
    localparam int OutDataW  = 80;
    localparam int FuncW     = 2;

    // x / 100 == (x * Recip100) >> RecipShift for every 32-bit unsigned x
    localparam logic [WordW-1:0] Recip100   = 32'h51EB851F;
    localparam int               RecipShift = 37;

    localparam int OpInput = 10;
    localparam int OpPrint = 11;
    localparam int OpLoad  = 20;
    localparam int OpStore = 21;
    localparam int OpAdd   = 30;
    localparam int OpSub   = 31;
    localparam int OpMul   = 32;
    localparam int OpDiv   = 33;
    localparam int OpJmp   = 40;
    localparam int OpJmpn  = 41;
    localparam int OpJmpz  = 42;
    // HALT is opcode -1: negative word with quotient magnitude one
    localparam int HaltMag = 1;

    typedef enum logic [FuncW-1:0] {
        FUNC_WRITE,
        FUNC_READ,
        FUNC_RESTART,
        FUNC_EXEC
    } t_func;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_RDWAIT,
        S_FETCH,
        S_SCALE,
        S_REMAIN,
        S_OPREAD,
        S_EXEC,
        S_DIVWAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic             we;
        logic [AddrW-1:0] waddr;
        logic [WordW-1:0] wdata;
        logic [AddrW-1:0] raddr;
    } t_mem_req;

endpackage

FILE: hw/rtl/dam_word_mem.sv
module dam_word_mem (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  dam_pkg::t_mem_req          i_req,
    output logic [dam_pkg::WordW-1:0]  o_rdata
);
    import dam_pkg::*;

    logic [WordW-1:0] r_mem [MemWords];
    logic [MemWords-1:0] r_vld;
    logic [WordW-1:0] r_rdata;
    logic             r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    // never-written words read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_req.we) begin
                r_vld[i_req.waddr] <= 1'b1;
            end
            r_rvld <= r_vld[i_req.raddr];
        end
    end

    assign o_rdata = r_rvld ? r_rdata : '0;

endmodule

FILE: hw/rtl/dam_div_unit.sv
module dam_div_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [dam_pkg::WordW-1:0]  i_dividend,
    input  logic [dam_pkg::WordW-1:0]  i_divisor,
    output logic                       o_done,
    output logic [dam_pkg::WordW-1:0]  o_quotient
);
    import dam_pkg::*;

    localparam int CntW = $clog2(WordW);

    logic            r_busy;
    logic            r_done;
    logic [CntW-1:0] r_cnt;
    logic [WordW-1:0] r_rem;
    logic [WordW-1:0] r_quo;
    logic [WordW-1:0] r_dvsr;
    logic            r_neg;

    logic [WordW:0]   w_shift;
    logic [WordW:0]   w_diff;
    logic             w_fits;
    logic [WordW-1:0] w_abs_a;
    logic [WordW-1:0] w_abs_b;

    assign w_shift = {r_rem, r_quo[WordW-1]};
    assign w_diff  = w_shift - {1'b0, r_dvsr};
    assign w_fits  = !w_diff[WordW];
    assign w_abs_a = i_dividend[WordW-1] ? -i_dividend : i_dividend;
    assign w_abs_b = i_divisor[WordW-1] ? -i_divisor : i_divisor;

    // restoring division on magnitudes, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= w_abs_a;
                r_dvsr <= w_abs_b;
                r_neg  <= i_dividend[WordW-1] ^ i_divisor[WordW-1];
            end else if (r_busy) begin
                r_rem <= w_fits ? w_diff[WordW-1:0] : w_shift[WordW-1:0];
                r_quo <= {r_quo[WordW-2:0], w_fits};
                r_cnt <= r_cnt + CntW'(1);
                if (r_cnt == CntW'(WordW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? -r_quo : r_quo;

endmodule

FILE: hw/rtl/decimal_accumulator_machine_core.sv
// Write, restart and execute past the end go dispatch to done; read adds a memory wait; execute
// adds fetch, decode and operand read, then exec unless HALT or a negative word with nonzero
// operand; a DIV by nonzero adds a divider wait. One item at a time: the next transfer is
// accepted the cycle after the result loads; a stalled result holds the next item in S_DONE.
// The word memory is read for the fetch and the operand, the opcode split costs two multiply
// stages, DIV runs a 32-step divider. Sync active-low reset: pc, acc zero, all words read zero.
module decimal_accumulator_machine_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [6:0] address, [38:7] value, [39] zero
    input  logic [dam_pkg::InDataW-1:0]   s_axis_tdata,
    // [1:0] func
    input  logic [dam_pkg::FuncW-1:0]     s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [31:0] word_out, [32] input_taken, [33] run_ended, [34] divide_fault,
    // [41:35] pc_now, [73:42] acc_now, [79:74] zero
    output logic [dam_pkg::OutDataW-1:0]  m_axis_tdata,
    // [0] printed
    output logic                          m_axis_tuser
);
    import dam_pkg::*;

    t_state r_state, n_state;

    t_func            r_func;
    logic [AddrW-1:0] r_addr;
    logic [WordW-1:0] r_value;
    logic [AddrW-1:0] r_pc;
    logic [WordW-1:0] r_acc;
    logic [WordW-1:0] r_absw;
    logic             r_neg;
    logic [QuoW-1:0]  r_q;
    logic [AddrW-1:0] r_rem;
    logic [WordW-1:0] r_word_res;
    logic             r_printed;
    logic             r_taken;
    logic             r_fault;

    logic                r_out_valid;
    logic [OutDataW-1:0] r_out_data;
    logic                r_out_user;

    t_mem_req         w_mem_req;
    logic [WordW-1:0] w_rdata;
    logic             w_div_start;
    logic             w_div_done;
    logic [WordW-1:0] w_quotient;
    logic             w_in_fire;
    logic             w_out_free;
    logic             w_load_out;
    logic             w_addr_ok;
    logic             w_pc_ok;
    logic [2*WordW-1:0] w_prod;
    logic [WordW-1:0] w_rem_full;
    logic [QuoW-1:0]  w_opc;
    logic             w_is_halt;
    logic             w_opnd_ok;
    logic [AddrW-1:0] w_jump_pc;
    logic             w_run_ended;

    dam_word_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mem_req),
        .o_rdata (w_rdata)
    );

    dam_div_unit u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_acc),
        .i_divisor  (w_rdata),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    assign w_in_fire  = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_addr_ok  = r_addr < AddrW'(MemWords);
    assign w_pc_ok    = r_pc < AddrW'(MemWords);

    // opcode = word / 100 and operand = word % 100 on the magnitude
    assign w_prod     = {{WordW{1'b0}}, r_absw} * {{WordW{1'b0}}, Recip100};
    assign w_rem_full = r_absw - ({{(WordW-QuoW){1'b0}}, r_q} * WordW'(MemWords));
    assign w_opc      = r_neg ? '0 : r_q;
    assign w_is_halt  = r_neg && (r_q == QuoW'(HaltMag));
    assign w_opnd_ok  = !r_neg || (r_rem == '0);
    assign w_jump_pc  = r_rem + AddrW'(1);
    assign w_run_ended = !w_pc_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        w_load_out    = 1'b0;
        w_div_start   = 1'b0;
        w_mem_req     = '0;
        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (w_in_fire) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (r_func)
                    FUNC_WRITE: begin
                        w_mem_req.we    = w_addr_ok;
                        w_mem_req.waddr = r_addr;
                        w_mem_req.wdata = r_value;
                        n_state = S_DONE;
                    end
                    FUNC_READ: begin
                        w_mem_req.raddr = w_addr_ok ? r_addr : '0;
                        n_state = S_RDWAIT;
                    end
                    FUNC_RESTART: begin
                        n_state = S_DONE;
                    end
                    FUNC_EXEC: begin
                        w_mem_req.raddr = w_pc_ok ? r_pc : '0;
                        n_state = w_pc_ok ? S_FETCH : S_DONE;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_RDWAIT: n_state = S_DONE;
            S_FETCH:  n_state = S_SCALE;
            S_SCALE:  n_state = S_REMAIN;
            S_REMAIN: n_state = S_OPREAD;
            S_OPREAD: begin
                w_mem_req.raddr = r_rem;
                n_state = (w_is_halt || !w_opnd_ok) ? S_DONE : S_EXEC;
            end
            S_EXEC: begin
                n_state = S_DONE;
                if (w_opc == QuoW'(OpInput)) begin
                    w_mem_req.we    = 1'b1;
                    w_mem_req.waddr = r_rem;
                    w_mem_req.wdata = r_value;
                end else if (w_opc == QuoW'(OpStore)) begin
                    w_mem_req.we    = 1'b1;
                    w_mem_req.waddr = r_rem;
                    w_mem_req.wdata = r_acc;
                end else if (w_opc == QuoW'(OpDiv) && w_rdata != '0) begin
                    w_div_start = 1'b1;
                    n_state     = S_DIVWAIT;
                end
            end
            S_DIVWAIT: begin
                if (w_div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // machine state: pc and accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc  <= '0;
            r_acc <= '0;
        end else begin
            unique case (r_state)
                S_DISPATCH: begin
                    if (r_func == FUNC_RESTART) begin
                        r_pc <= '0;
                    end
                end
                S_OPREAD: begin
                    if (w_is_halt) begin
                        r_pc <= AddrW'(MemWords);
                    end else if (!w_opnd_ok) begin
                        r_pc <= r_pc + AddrW'(1);
                    end
                end
                S_EXEC: begin
                    r_pc <= r_pc + AddrW'(1);
                    unique case (w_opc)
                        QuoW'(OpLoad): r_acc <= w_rdata;
                        QuoW'(OpAdd):  r_acc <= r_acc + w_rdata;
                        QuoW'(OpSub):  r_acc <= r_acc - w_rdata;
                        QuoW'(OpMul):  r_acc <= r_acc * w_rdata;
                        QuoW'(OpJmp):  r_pc  <= w_jump_pc;
                        QuoW'(OpJmpn): begin
                            if (r_acc[WordW-1]) begin
                                r_pc <= w_jump_pc;
                            end
                        end
                        QuoW'(OpJmpz): begin
                            if (r_acc == '0) begin
                                r_pc <= w_jump_pc;
                            end
                        end
                        default: ;
                    endcase
                end
                S_DIVWAIT: begin
                    if (w_div_done) begin
                        r_acc <= w_quotient;
                    end
                end
                default: ;
            endcase
        end
    end

    // item capture, decode and result flags
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    r_func     <= t_func'(s_axis_tuser);
                    r_addr     <= s_axis_tdata[AddrW-1:0];
                    r_value    <= s_axis_tdata[AddrW+WordW-1:AddrW];
                    r_word_res <= '0;
                    r_printed  <= 1'b0;
                    r_taken    <= 1'b0;
                    r_fault    <= 1'b0;
                end
            end
            S_RDWAIT: begin
                r_word_res <= w_addr_ok ? w_rdata : '0;
            end
            S_FETCH: begin
                r_neg  <= w_rdata[WordW-1];
                r_absw <= w_rdata[WordW-1] ? -w_rdata : w_rdata;
            end
            S_SCALE: begin
                r_q <= w_prod[RecipShift+QuoW-1:RecipShift];
            end
            S_REMAIN: begin
                r_rem <= w_rem_full[AddrW-1:0];
            end
            S_EXEC: begin
                unique case (w_opc)
                    QuoW'(OpInput): r_taken <= 1'b1;
                    QuoW'(OpPrint): begin
                        r_word_res <= w_rdata;
                        r_printed  <= 1'b1;
                    end
                    QuoW'(OpDiv): r_fault <= (w_rdata == '0);
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // output register: holds a finished result until the transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_data <= {{(OutDataW-2*WordW-AddrW-3){1'b0}}, r_acc, r_pc, r_fault,
                           w_run_ended, r_taken, r_word_res};
            r_out_user <= r_printed;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && !m_axis_tready) |=> (r_state == S_DONE))
        else $error("finished result dropped while output stalled");

    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc <= AddrW'(MemWords))
        else $error("program counter beyond end mark");

    a_mem_write_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_req.we |-> (w_mem_req.waddr < AddrW'(MemWords)))
        else $error("word memory write out of range");

    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIVWAIT))
        else $error("divider finished outside divide wait");

endmodule
